// ===== rtl/core/cpsc_pkg.sv =====
package cpsc_pkg;

  // Fixed widths of the item fields.
  localparam int ID_W = 10;
  localparam int OP_W = 2;

  // Operation codes on the op input.
  localparam logic [OP_W-1:0] OP_PAIR   = 2'd0;
  localparam logic [OP_W-1:0] OP_MEMBER = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Result kinds.
  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Defaults for the top level parameters.
  localparam int DEF_MAX_PAIRS = 1024;
  localparam int DEF_NUM_IDS   = 1024;

  // Membership epoch tag width and command queue depth.
  localparam int EP_W    = 8;
  localparam int Q_DEPTH = 2;

  // Command carried from the front to the back.
  typedef enum logic [1:0] {
    CMD_PAIR,
    CMD_MEMBER,
    CMD_QUERY
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_SCAN
  } back_state_e;

endpackage

// ===== rtl/core/conflict_pair_set_checker_core.sv =====
// Pair and member beats are taken one per cycle while the command queue has room
// and no bitmap sweep runs. A query scan reads one stored pair per cycle through a
// three-stage table/bitmap pipe; a rejection is registered and strobed once the back
// end takes its pair beat. After reset, and after every 255th query, a bitmap sweep
// over all NUM_IDS tags runs with busy_o high. Results are strobed on done_o for one
// cycle; no backpressure.
module conflict_pair_set_checker_core
  import cpsc_pkg::*;
#(
  parameter int MAX_PAIRS = DEF_MAX_PAIRS,
  parameter int NUM_IDS   = DEF_NUM_IDS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [OP_W-1:0] op_i,
  input  logic [ID_W-1:0] first_id_i,
  input  logic [ID_W-1:0] second_id_i,
  output logic            done_o,
  output logic            kind_o,
  output logic            safe_o
);

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;
  logic      push;
  logic      pop;
  logic      clearing;

  // Front end: accept and classify beats.
  cpsc_front #(
    .NUM_IDS (NUM_IDS)
  ) u_front (
    .start_i     (start_i),
    .op_i        (op_i),
    .first_id_i  (first_id_i),
    .second_id_i (second_id_i),
    .q_status_i  (q_status),
    .clearing_i  (clearing),
    .busy_o      (busy_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Command queue between the two halves.
  cpsc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .status_o    (q_status)
  );

  // Back end: table updates, membership and scans.
  cpsc_back #(
    .MAX_PAIRS (MAX_PAIRS),
    .NUM_IDS   (NUM_IDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_data_i   (pop_cmd),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .kind_o     (kind_o),
    .safe_o     (safe_o)
  );

endmodule

// ===== rtl/core/cpsc_fifo.sv =====
module cpsc_fifo
  import cpsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      push_data_i,
  input  logic      pop_i,
  output cmd_t      pop_data_o,
  output q_status_t status_o
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage for queued beats.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o      = mem_q[rd_ptr_q];
  assign status_o.full   = (cnt_q == CNT_W'(Q_DEPTH));
  assign status_o.empty  = (cnt_q == '0);

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !(push_i && !pop_i))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("command queue underflow");
`endif

endmodule

// ===== rtl/core/cpsc_front.sv =====
module cpsc_front
  import cpsc_pkg::*;
#(
  parameter int NUM_IDS = DEF_NUM_IDS
) (
  input  logic            start_i,
  input  logic [OP_W-1:0] op_i,
  input  logic [ID_W-1:0] first_id_i,
  input  logic [ID_W-1:0] second_id_i,
  input  q_status_t       q_status_i,
  input  logic            clearing_i,
  output logic            busy_o,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic accept;
  logic keep;

  // Hold off new beats while the queue is full or the bitmap is swept.
  assign busy_o = q_status_i.full || clearing_i;
  assign accept = start_i && !busy_o;

  // Classify the beat; unused ops and out-of-range members are dropped here.
  always_comb begin
    keep          = 1'b0;
    cmd_o.cmd     = CMD_QUERY;
    cmd_o.first_id  = first_id_i;
    cmd_o.second_id = second_id_i;
    unique case (op_i)
      OP_PAIR: begin
        keep      = 1'b1;
        cmd_o.cmd = CMD_PAIR;
      end
      OP_MEMBER: begin
        keep      = (32'(first_id_i) < NUM_IDS);
        cmd_o.cmd = CMD_MEMBER;
      end
      OP_QUERY: begin
        keep      = 1'b1;
        cmd_o.cmd = CMD_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept && keep;

endmodule

// ===== rtl/core/cpsc_back.sv =====
module cpsc_back
  import cpsc_pkg::*;
#(
  parameter int MAX_PAIRS = DEF_MAX_PAIRS,
  parameter int NUM_IDS   = DEF_NUM_IDS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  cmd_t      q_data_i,
  output logic      pop_o,
  output logic      clearing_o,
  output logic      done_o,
  output logic      kind_o,
  output logic      safe_o
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int PA_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int BM_AW = $clog2(NUM_IDS);

  back_state_e state_q, state_d;
  logic [BM_AW-1:0] clr_idx_q, clr_idx_d;
  logic [EP_W-1:0]  epoch_q, epoch_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             hit_q, hit_d;
  logic             v1_q, v1_d;
  logic             v2_q;
  logic             done_q, done_d;
  logic             kind_q, kind_d;
  logic             safe_q, safe_d;

  // Pair table and membership tags.
  logic [2*ID_W-1:0] store_mem [MAX_PAIRS];
  logic [EP_W-1:0]   bm_mem [NUM_IDS];

  logic              st_we, st_re;
  logic [PA_W-1:0]   st_waddr, st_raddr;
  logic [2*ID_W-1:0] st_wdata;
  logic [2*ID_W-1:0] pair_rd_q;
  logic              bm_we;
  logic [BM_AW-1:0]  bm_waddr;
  logic [EP_W-1:0]   bm_wdata;
  logic [ID_W-1:0]   id_a, id_b;
  logic [EP_W-1:0]   tag_a_q, tag_b_q;
  logic              rng_q;

  // Map an id onto a bitmap address, extending or truncating as needed.
  function automatic logic [BM_AW-1:0] to_idx(input logic [ID_W-1:0] id);
    logic [BM_AW+ID_W-1:0] ext;
    ext = (BM_AW + ID_W)'(id);
    return ext[BM_AW-1:0];
  endfunction

  assign id_a     = pair_rd_q[ID_W-1:0];
  assign id_b     = pair_rd_q[2*ID_W-1:ID_W];
  assign st_waddr = count_q[PA_W-1:0];
  assign st_raddr = k_q[PA_W-1:0];
  assign st_wdata = {q_data_i.second_id, q_data_i.first_id};

  // Sequencer: sweep, command execution and pair scan.
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    epoch_d   = epoch_q;
    count_d   = count_q;
    k_d       = k_q;
    hit_d     = hit_q;
    v1_d      = 1'b0;
    done_d    = 1'b0;
    kind_d    = KIND_ANSWER;
    safe_d    = 1'b0;
    pop_o     = 1'b0;
    st_we     = 1'b0;
    st_re     = 1'b0;
    bm_we     = 1'b0;
    bm_waddr  = to_idx(q_data_i.first_id);
    bm_wdata  = epoch_q;

    // A pair is a hit when both ids are in range and carry the current epoch tag.
    if (v2_q && rng_q && (tag_a_q == epoch_q) && (tag_b_q == epoch_q)) begin
      hit_d = 1'b1;
    end

    unique case (state_q)
      BK_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_idx_q;
        bm_wdata = '0;
        if (clr_idx_q == BM_AW'(NUM_IDS - 1)) begin
          clr_idx_d = '0;
          epoch_d   = EP_W'(1);
          state_d   = BK_RUN;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      BK_RUN: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          case (q_data_i.cmd)
            CMD_PAIR: begin
              if (count_q == CNT_W'(MAX_PAIRS)) begin
                done_d = 1'b1;
                kind_d = KIND_REJECT;
                safe_d = 1'b0;
              end else begin
                st_we   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            CMD_MEMBER: begin
              bm_we = 1'b1;
            end
            CMD_QUERY: begin
              k_d     = '0;
              hit_d   = 1'b0;
              state_d = BK_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (k_q < count_q) begin
          st_re = 1'b1;
          v1_d  = 1'b1;
          k_d   = k_q + 1'b1;
        end else if (!v1_q && !v2_q) begin
          done_d = 1'b1;
          kind_d = KIND_ANSWER;
          safe_d = !hit_q;
          // Epoch wrap forces a full sweep so stale tags cannot alias.
          if (epoch_q == '1) begin
            state_d = BK_CLEAR;
          end else begin
            epoch_d = epoch_q + 1'b1;
            state_d = BK_RUN;
          end
        end
      end
      default: begin
        state_d = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_idx_q <= '0;
      epoch_q   <= EP_W'(1);
      count_q   <= '0;
      k_q       <= '0;
      hit_q     <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      epoch_q   <= epoch_d;
      count_q   <= count_d;
      k_q       <= k_d;
      hit_q     <= hit_d;
      v1_q      <= v1_d;
      v2_q      <= v1_q;
      done_q    <= done_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    safe_q <= safe_d;
  end

  // Pair table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      pair_rd_q <= store_mem[st_raddr];
    end
  end

  // Membership tags: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (v1_q) begin
      tag_a_q <= bm_mem[to_idx(id_a)];
      tag_b_q <= bm_mem[to_idx(id_b)];
      rng_q   <= (32'(id_a) < NUM_IDS) && (32'(id_b) < NUM_IDS);
    end
  end

  assign clearing_o = (state_q == BK_CLEAR);
  assign done_o     = done_q;
  assign kind_o     = kind_q;
  assign safe_o     = safe_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PAIRS))
    else $error("pair count beyond table size");

  a_reject_unsafe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (kind_o == KIND_REJECT)) |-> !safe_o)
    else $error("rejection flagged as safe");

  a_no_pop_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CLEAR) |-> !pop_o)
    else $error("command taken during bitmap sweep");

  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (state_q == BK_SCAN))
    else $error("scan pipeline active outside scan");
`endif

endmodule

// ===== sim/conflict_pair_set_checker_core_tb.sv =====
`timescale 1ns / 1ps

module conflict_pair_set_checker_core_tb;
  import cpsc_pkg::*;

  localparam int MAX_PAIRS = DEF_MAX_PAIRS;
  localparam int NUM_IDS   = DEF_NUM_IDS;
  localparam realtime CLK_PERIOD = 12.0;

  // Op 3 has no meaning to the block and must leave it untouched.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Pairs stored during the random part stay few so that query scans stay short.
  localparam int RANDOM_PAIR_CAP = 220;
  localparam int BEATS_PER_PHASE = 25;

  // Longest quiet stretch of a correct run: a bitmap sweep, a full-table scan and
  // sender gaps, taken several times over.
  localparam int QUIET_LIMIT = 8 * (MAX_PAIRS + NUM_IDS) + 1000;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
    int unsigned     idle_pct;
  } beat_t;

  typedef struct packed {
    logic kind;
    logic safe;
  } verdict_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start_i     = 1'b0;
  logic [OP_W-1:0] op_i        = OP_QUERY;
  logic [ID_W-1:0] first_id_i  = '0;
  logic [ID_W-1:0] second_id_i = '0;
  logic            busy_o;
  logic            done_o;
  logic            kind_o;
  logic            safe_o;

  beat_t    pending_beats[$];
  verdict_t expected_verdicts[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;

  // Shadow copy of the forbidden pair table and the current set.
  logic [ID_W-1:0]  forbid_first[MAX_PAIRS];
  logic [ID_W-1:0]  forbid_second[MAX_PAIRS];
  int unsigned      forbid_count = 0;
  bit [NUM_IDS-1:0] member_map = '0;

  conflict_pair_set_checker_core #(
    .MAX_PAIRS(MAX_PAIRS),
    .NUM_IDS  (NUM_IDS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .op_i       (op_i),
    .first_id_i (first_id_i),
    .second_id_i(second_id_i),
    .done_o     (done_o),
    .kind_o     (kind_o),
    .safe_o     (safe_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Update the shadow state for one accepted beat and work out its verdict, if any.
  function automatic void predict_verdict(input logic [OP_W-1:0] op,
                                          input logic [ID_W-1:0] a,
                                          input logic [ID_W-1:0] b,
                                          output bit has_verdict,
                                          output verdict_t v);
    bit clash;
    has_verdict = 1'b0;
    clash       = 1'b0;
    v.kind      = KIND_ANSWER;
    v.safe      = 1'b0;
    case (op)
      OP_PAIR: begin
        if (forbid_count >= MAX_PAIRS) begin
          // The table is full, so the pair is dropped and flagged.
          has_verdict = 1'b1;
          v.kind      = KIND_REJECT;
        end else begin
          forbid_first[forbid_count]  = a;
          forbid_second[forbid_count] = b;
          forbid_count++;
        end
      end
      OP_MEMBER: begin
        if (a < NUM_IDS) member_map[a] = 1'b1;
      end
      OP_QUERY: begin
        for (int k = 0; k < forbid_count; k++) begin
          if (forbid_first[k] < NUM_IDS && forbid_second[k] < NUM_IDS &&
              member_map[forbid_first[k]] && member_map[forbid_second[k]]) begin
            clash = 1'b1;
          end
        end
        has_verdict = 1'b1;
        v.safe      = !clash;
        member_map  = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void add_beat(input logic [OP_W-1:0] op, input int a, input int b,
                                   input int unsigned pct);
    beat_t item;
    item.op        = op;
    item.first_id  = a[ID_W-1:0];
    item.second_id = b[ID_W-1:0];
    item.idle_pct  = pct;
    pending_beats = {pending_beats, item};
  endfunction

  // Ids cluster on two small hot ranges at both ends so that sets hit stored pairs often.
  function automatic int rand_id();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(0, 15);
    if (pick < 70) return $urandom_range(1008, 1023);
    return $urandom_range(0, 1023);
  endfunction

  function automatic int add_pair(input int unsigned pct);
    int a;
    a = rand_id();
    add_beat(OP_PAIR, a, ($urandom_range(0, 9) == 0) ? a : rand_id(), pct);
    return 1;
  endfunction

  // A set of members, repeats allowed, closed by a query.
  function automatic int add_set(input int members, input int unsigned pct);
    int a;
    a = rand_id();
    for (int k = 0; k < members; k++) begin
      if ($urandom_range(0, 4) != 0) a = rand_id();
      add_beat(OP_MEMBER, a, $urandom_range(0, 1023), pct);
    end
    add_beat(OP_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023), pct);
    return members + 1;
  endfunction

  // Driver: offer the next beat once the current one is taken or none is up.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    beat_t    item;
    verdict_t outcome;
    bit       has_verdict;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predict_verdict(op_i, first_id_i, second_id_i, has_verdict, outcome);
        if (has_verdict) expected_verdicts = {expected_verdicts, outcome};
      end
      if (!start_i || !busy_o) begin
        if (pending_beats.size() != 0 &&
            $urandom_range(0, 99) >= pending_beats[0].idle_pct) begin
          item = pending_beats.pop_front();
          start_i     <= 1'b1;
          op_i        <= item.op;
          first_id_i  <= item.first_id;
          second_id_i <= item.second_id;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected verdict.
  always @(posedge clk_i) begin : observe
    verdict_t want;
    if (rst_ni && done_o) begin
      if (expected_verdicts.size() == 0) begin
        flag_mismatch($sformatf("result kind=%0b safe=%0b with none expected",
                                kind_o, safe_o));
      end else begin
        want = expected_verdicts.pop_front();
        if (kind_o !== want.kind)
          flag_mismatch($sformatf("kind %0b, expected %0b", kind_o, want.kind));
        if (safe_o !== want.safe)
          flag_mismatch($sformatf("safe %0b, expected %0b", safe_o, want.safe));
      end
    end
  end

  // Watchdog on stretches with no beat taken and no result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("conflict_pair_set_checker_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_idle[4] = '{0, 57, 0, 34};
    int unsigned pct;
    int          pairs_made;
    int          counted;
    int          pick;
    int          unused;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty sets, extreme ids, a pair of one id, repeats, op 3.
    add_beat(OP_QUERY, 0, 0, 0);
    add_beat(OP_MEMBER, 5, 1023, 0);
    add_beat(OP_QUERY, 1023, 1023, 0);
    add_beat(OP_PAIR, 0, 1023, 0);
    add_beat(OP_PAIR, 7, 7, 0);
    add_beat(OP_PAIR, 12, 34, 0);
    add_beat(OP_PAIR, 1023, 1023, 0);
    add_beat(OP_MEMBER, 0, 0, 0);
    add_beat(OP_MEMBER, 1023, 0, 0);
    add_beat(OP_QUERY, 0, 0, 0);
    add_beat(OP_MEMBER, 7, 0, 0);
    add_beat(OP_MEMBER, 7, 1023, 0);
    add_beat(OP_QUERY, 0, 0, 0);
    add_beat(OP_MEMBER, 12, 0, 0);
    add_beat(OP_QUERY, 0, 0, 0);
    // The bitmap was cleared, so 12 alone is no longer a member.
    add_beat(OP_MEMBER, 34, 0, 0);
    add_beat(OP_QUERY, 0, 0, 0);
    add_beat(OP_MEMBER, 12, 0, 0);
    add_beat(OP_MEMBER, 34, 0, 0);
    add_beat(OP_QUERY, 0, 0, 0);
    // An unused op carrying an id must not mark it as a member.
    add_beat(OP_UNUSED, 0, 1023, 0);
    add_beat(OP_MEMBER, 1023, 0, 0);
    add_beat(OP_QUERY, 0, 0, 0);
    add_beat(OP_QUERY, 1023, 0, 0);
    pairs_made = 4;

    // Random part: mostly pair batches and well-formed sets, some open sets and noise.
    for (int phase = 0; phase < 4; phase++) begin
      pct     = phase_idle[phase];
      counted = 0;
      while (counted < BEATS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 25 && pairs_made < RANDOM_PAIR_CAP) begin
          repeat ($urandom_range(1, 4)) begin
            counted += add_pair(pct);
            pairs_made++;
          end
        end else if (pick < 88) begin
          counted += add_set($urandom_range(0, 6), pct);
        end else if (pick < 95) begin
          // Members with no query; they carry over into the next set.
          repeat ($urandom_range(1, 3)) begin
            add_beat(OP_MEMBER, rand_id(), $urandom_range(0, 1023), pct);
            counted++;
          end
        end else begin
          add_beat(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023), pct);
        end
      end
    end

    // Fill the table, then push past it so appends are rejected.
    while (pairs_made < MAX_PAIRS) begin
      add_beat(OP_PAIR, $urandom_range(0, 1023), $urandom_range(0, 1023), 34);
      pairs_made++;
      if (pairs_made % 100 == 0) unused = add_set($urandom_range(0, 6), 34);
    end
    for (int k = 0; k < 24; k++) begin
      add_beat(OP_PAIR, rand_id(), rand_id(), 57);
      if (k % 3 == 0) unused = add_set($urandom_range(0, 6), 57);
    end
    unused = add_set(0, 0);

    // Let everything be taken and answered, then watch for strays.
    while (pending_beats.size() != 0 || start_i) @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (MAX_PAIRS + 16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("conflict_pair_set_checker_core_tb: clean");
    end else begin
      $display("conflict_pair_set_checker_core_tb: errors");
    end
    $finish;
  end

endmodule
